// ----- rtl/core/swq_pkg.sv -----
// shared constants, codes and control structs of the sorted wait queue
// depends on nothing; every other file of the block refers to it by scoped names
package swq_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ID_W     = 16;
  localparam int KEY_W    = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a result for the accepted beat
    logic op;     // opcode of the accepted beat
    logic push;   // insert the entry into the queue
    logic pop;    // remove the head entry
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } flags_t;

endpackage

// ----- rtl/core/swq_req_if.sv -----
// request channel of the sorted wait queue: opcode, process id and key
// depends on swq_pkg
interface swq_req_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [swq_pkg::ID_W-1:0]  proc_id;
  logic [swq_pkg::KEY_W-1:0] io_wait;

  modport source (output valid, opcode, proc_id, io_wait, input ready);
  modport sink   (input valid, opcode, proc_id, io_wait, output ready);
endinterface

// ----- rtl/core/swq_rsp_if.sv -----
// response channel of the sorted wait queue: status, popped entry, occupancy
// depends on swq_pkg
interface swq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [swq_pkg::STATUS_W-1:0] status;
  logic [swq_pkg::ID_W-1:0]     out_proc_id;
  logic [swq_pkg::KEY_W-1:0]    out_io_wait;
  logic [swq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_proc_id, out_io_wait, occupancy, input ready);
  modport sink   (input valid, status, out_proc_id, out_io_wait, occupancy, output ready);
endinterface

// ----- rtl/core/swq_datapath.sv -----
// shift-register entry store, fill count and result register of the queue
// depends on swq_pkg; driven by swq_ctrl through cmd_t
module swq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swq_pkg::cmd_t                cmd_i,
  input  logic [swq_pkg::ID_W-1:0]     id_i,
  input  logic [swq_pkg::KEY_W-1:0]    key_i,
  output swq_pkg::flags_t              flags_o,
  output logic [swq_pkg::STATUS_W-1:0] status_o,
  output logic [swq_pkg::ID_W-1:0]     id_o,
  output logic [swq_pkg::KEY_W-1:0]    key_o,
  output logic [swq_pkg::OCC_W-1:0]    occ_o
);

  logic [swq_pkg::ID_W-1:0]  ids_q  [swq_pkg::DEPTH];
  logic [swq_pkg::ID_W-1:0]  ids_d  [swq_pkg::DEPTH];
  logic [swq_pkg::KEY_W-1:0] keys_q [swq_pkg::DEPTH];
  logic [swq_pkg::KEY_W-1:0] keys_d [swq_pkg::DEPTH];
  logic [swq_pkg::ID_W-1:0]  up_id  [swq_pkg::DEPTH];
  logic [swq_pkg::KEY_W-1:0] up_key [swq_pkg::DEPTH];
  logic [swq_pkg::ID_W-1:0]  dn_id  [swq_pkg::DEPTH];
  logic [swq_pkg::KEY_W-1:0] dn_key [swq_pkg::DEPTH];
  logic [swq_pkg::DEPTH-1:0] le;
  logic [swq_pkg::DEPTH-1:0] le_prev;
  logic [swq_pkg::CNT_W-1:0] cnt_q, cnt_d;

  logic [swq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [swq_pkg::ID_W-1:0]     res_id_q, res_id_d;
  logic [swq_pkg::KEY_W-1:0]    res_key_q, res_key_d;
  logic [swq_pkg::OCC_W-1:0]    occ_q;

  assign flags_o.full  = (cnt_q == swq_pkg::CNT_W'(swq_pkg::DEPTH));
  assign flags_o.empty = (cnt_q == '0);

  // per slot: held and key not above the new one (a prefix, since keys ascend)
  for (genvar g = 0; g < swq_pkg::DEPTH; g++) begin : g_slot
    localparam logic [swq_pkg::CNT_W-1:0] SlotIdx = swq_pkg::CNT_W'(g);
    assign le[g] = (SlotIdx < cnt_q) && (keys_q[g] <= key_i);
    if (g == 0) begin : g_first
      assign up_id[g]  = id_i;
      assign up_key[g] = key_i;
    end else begin : g_rest
      assign up_id[g]  = ids_q[g-1];
      assign up_key[g] = keys_q[g-1];
    end
    if (g == swq_pkg::DEPTH - 1) begin : g_last
      assign dn_id[g]  = ids_q[g];
      assign dn_key[g] = keys_q[g];
    end else begin : g_inner
      assign dn_id[g]  = ids_q[g+1];
      assign dn_key[g] = keys_q[g+1];
    end
  end

  assign le_prev = {le[swq_pkg::DEPTH-2:0], 1'b1};

  always_comb begin
    for (int i = 0; i < swq_pkg::DEPTH; i++) begin
      ids_d[i]  = ids_q[i];
      keys_d[i] = keys_q[i];
      if (cmd_i.push) begin
        if (!le[i]) begin
          if (le_prev[i]) begin
            ids_d[i]  = id_i;
            keys_d[i] = key_i;
          end else begin
            ids_d[i]  = up_id[i];
            keys_d[i] = up_key[i];
          end
        end
      end else if (cmd_i.pop) begin
        ids_d[i]  = dn_id[i];
        keys_d[i] = dn_key[i];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.push) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    res_id_d  = '0;
    res_key_d = '0;
    if (cmd_i.op == swq_pkg::OP_PUSH) begin
      status_d = flags_o.full ? swq_pkg::ST_FULL : swq_pkg::ST_PUSHED;
    end else if (flags_o.empty) begin
      status_d = swq_pkg::ST_EMPTY;
    end else begin
      status_d  = swq_pkg::ST_POPPED;
      res_id_d  = ids_q[0];
      res_key_d = keys_q[0];
    end
  end

  // entry store holds no reset, only slots below the count are ever read
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < swq_pkg::DEPTH; i++) begin
      ids_q[i]  <= ids_d[i];
      keys_q[i] <= keys_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q  <= status_d;
      res_id_q  <= res_id_d;
      res_key_q <= res_key_d;
      occ_q     <= swq_pkg::OCC_W'(cnt_d);
    end
  end

  assign status_o = status_q;
  assign id_o     = res_id_q;
  assign key_o    = res_key_q;
  assign occ_o    = occ_q;

endmodule

// ----- rtl/core/swq_ctrl.sv -----
// handshake controller of the queue: result register state and datapath commands
// depends on swq_pkg; commands swq_datapath through cmd_t
module swq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_opcode_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  swq_pkg::flags_t flags_i,
  output swq_pkg::cmd_t   cmd_o
);

  localparam logic S_IDLE = 1'b0;  // result register empty
  localparam logic S_HOLD = 1'b1;  // result waiting on the response side

  logic state_q, state_d;
  logic accept;

  // a waiting result that leaves this cycle frees the register for the next beat
  assign req_ready_o = (state_q == S_IDLE) || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = (state_q == S_HOLD);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (rsp_ready_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.load = accept;
  assign cmd_o.op   = req_opcode_i;
  assign cmd_o.push = accept && (req_opcode_i == swq_pkg::OP_PUSH) && !flags_i.full;
  assign cmd_o.pop  = accept && (req_opcode_i == swq_pkg::OP_POP) && !flags_i.empty;

endmodule

// ----- rtl/core/sorted_wait_queue.sv -----
// sorted wait queue: a registered response beat follows in the cycle after its request beat
// one beat per cycle unless stalled; an insert or a head removal is one shift of the slot row
// a request is taken while the previous response is being taken in the same cycle
// reset clears the fill count and the response valid, the slot row itself is not cleared
// depends on swq_pkg, swq_req_if, swq_rsp_if, swq_ctrl and swq_datapath
module sorted_wait_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  swq_req_if.sink   req_i,
  swq_rsp_if.source rsp_o
);

  swq_pkg::cmd_t   cmd;
  swq_pkg::flags_t flags;

  // controller: owns the handshakes and decides push or pop per beat
  swq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .flags_i      (flags),
    .cmd_o        (cmd)
  );

  // datapath: sorted slot row, head at slot zero, plus the response register
  swq_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .id_i     (req_i.proc_id),
    .key_i    (req_i.io_wait),
    .flags_o  (flags),
    .status_o (rsp_o.status),
    .id_o     (rsp_o.out_proc_id),
    .key_o    (rsp_o.out_io_wait),
    .occ_o    (rsp_o.occupancy)
  );

endmodule

// ----- rtl/core/swq_checker.sv -----
// port-level checks of the sorted wait queue response stream
// depends on swq_pkg; bound to sorted_wait_queue below
module swq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [swq_pkg::STATUS_W-1:0] status_i,
  input logic [swq_pkg::ID_W-1:0]     id_i,
  input logic [swq_pkg::KEY_W-1:0]    key_i,
  input logic [swq_pkg::OCC_W-1:0]    occ_i
);

  // stalled response beat holds its valid, status and occupancy
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(occ_i))
    else $error("response changed while stalled");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == swq_pkg::ST_EMPTY) |-> occ_i == '0)
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == swq_pkg::ST_FULL)
      |-> occ_i == swq_pkg::OCC_W'(swq_pkg::DEPTH))
    else $error("full status below depth");

  a_push_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == swq_pkg::ST_PUSHED) |-> occ_i != '0)
    else $error("push left queue empty");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != swq_pkg::ST_POPPED) |-> id_i == '0 && key_i == '0)
    else $error("entry data on a non-pop response");

endmodule

bind sorted_wait_queue swq_checker u_swq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .id_i        (rsp_o.out_proc_id),
  .key_i       (rsp_o.out_io_wait),
  .occ_i       (rsp_o.occupancy)
);
